// ===== src/transaction_line_item_parser_top_defines.svh =====
// ----------------------------------------------------------------------------
// Transaction line-item parser: assertion macros
// Shared property wrappers for the parser's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef TRANSACTION_LINE_ITEM_PARSER_TOP_DEFINES_SVH
`define TRANSACTION_LINE_ITEM_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define TLIP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TLIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tlip_pkg.sv =====
// ----------------------------------------------------------------------------
// Transaction line-item parser package
// Character codes, scan mode codes and port field widths.
// ----------------------------------------------------------------------------
package tlip_pkg;

  // Port field widths
  localparam int unsigned DATA_W = 8;
  localparam int unsigned ITEM_W = 32;
  localparam int unsigned DIGIT_W = 4;

  // Character codes ('#' needs no code: it falls into the skip path like junk)
  localparam logic [DATA_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [DATA_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [DATA_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [DATA_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [DATA_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [DATA_W-1:0] CHAR_NINE  = 8'h39;

  // Scan mode codes; the unused code behaves as between tokens
  localparam int unsigned MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_GAP  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NUM  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SKIP = 2'd2;

endpackage

// ===== src/tlip_in_if.sv =====
// ----------------------------------------------------------------------------
// Parser byte channel
// Valid/ready channel carrying one text byte and its end-of-file mark.
// ----------------------------------------------------------------------------
interface tlip_in_if import tlip_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);

endinterface

// ===== src/tlip_out_if.sv =====
// ----------------------------------------------------------------------------
// Parser result channel
// Valid/ready channel carrying one item and/or row end per word.
// ----------------------------------------------------------------------------
interface tlip_out_if import tlip_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              item_valid;
  logic [ITEM_W-1:0] item_value;
  logic              row_end;
  logic [ITEM_W-1:0] largest_item;

  modport source (
    output valid, output item_valid, output item_value, output row_end,
    output largest_item, input ready
  );
  modport sink (
    input valid, input item_valid, input item_value, input row_end,
    input largest_item, output ready
  );

endinterface

// ===== src/tlip_digit_acc.sv =====
// ----------------------------------------------------------------------------
// Saturating decimal accumulator
// Computes acc * 10 + digit, clamped to all ones of the value width.
// ----------------------------------------------------------------------------
module tlip_digit_acc import tlip_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic [VALUE_BITS-1:0] acc_i,
  input  logic [DIGIT_W-1:0]    digit_i,
  output logic [VALUE_BITS-1:0] acc_o
);

  localparam int SUM_W = VALUE_BITS + 4;

  logic [SUM_W-1:0] acc_ext;
  logic [SUM_W-1:0] sum;

  // Times ten as two shifts, then add the digit
  assign acc_ext = {4'b0000, acc_i};
  assign sum     = (acc_ext << 3) + (acc_ext << 1) + {{(SUM_W-DIGIT_W){1'b0}}, digit_i};

  // Clamp when any bit above the value width is set
  assign acc_o = (|sum[SUM_W-1:VALUE_BITS]) ? {VALUE_BITS{1'b1}} : sum[VALUE_BITS-1:0];

endmodule

// ===== src/transaction_line_item_parser_top.sv =====
// ----------------------------------------------------------------------------
// Transaction line-item parser
// Splits a transaction text into decimal items and row ends, one byte a cycle.
// ----------------------------------------------------------------------------
//  channel  | dir | word                                            | handshake
//  ---------+-----+-------------------------------------------------+----------
//  in_i     | in  | data_byte, is_last                              | valid/ready
//  out_o    | out | item_valid, item_value, row_end, largest_item   | valid/ready
//
//  One byte per cycle; a result appears in the output register in the cycle
//  after its byte is taken. Scan state updates at accept, so the depth of one
//  saturating multiply-add plus the running-max compare sets the clock.
//  in_i.ready is low only while a result is held and out_o.ready is low.
//  Reset clears scan mode, accumulator, row flag, running max and out valid.
// ----------------------------------------------------------------------------
`include "transaction_line_item_parser_top_defines.svh"

module transaction_line_item_parser_top import tlip_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tlip_in_if.sink   in_i,
  tlip_out_if.source out_o
);

  // Scan state
  logic [MODE_W-1:0]     mode_q, mode_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic                  row_q, row_d;
  logic [VALUE_BITS-1:0] max_q, max_d;

  // Result register
  logic                  out_valid_q, out_valid_d;
  logic                  res_item_valid_q;
  logic [VALUE_BITS-1:0] res_item_q;
  logic                  res_row_end_q;

  logic                  in_fire;
  logic [DATA_W-1:0]     c;
  logic                  is_digit, is_sep, is_nl;
  logic [DIGIT_W-1:0]    digit;
  logic [VALUE_BITS-1:0] acc_next;
  logic [MODE_W-1:0]     mode_cur;
  logic                  have_item, row_close;
  logic [VALUE_BITS-1:0] item;

  // Accept while the result register is empty or draining
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // Classify the byte
  assign c        = in_i.data_byte;
  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign is_sep   = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR);
  assign is_nl    = (c == CHAR_NL);
  assign digit    = DIGIT_W'(c - CHAR_ZERO);

  tlip_digit_acc #(
    .VALUE_BITS (VALUE_BITS)
  ) u_digit_acc (
    .acc_i   (acc_q),
    .digit_i (digit),
    .acc_o   (acc_next)
  );

  // Per-byte scan step
  always_comb begin
    mode_cur  = (mode_q == MODE_NUM || mode_q == MODE_SKIP) ? mode_q : MODE_GAP;
    mode_d    = mode_cur;
    acc_d     = acc_q;
    row_d     = row_q;
    have_item = 1'b0;
    row_close = 1'b0;
    item      = '0;

    if (mode_cur == MODE_NUM && is_digit) begin
      acc_d = acc_next;
    end else if (mode_cur == MODE_SKIP) begin
      if (is_nl) begin
        row_close = row_q;
        row_d     = 1'b0;
        mode_d    = MODE_GAP;
      end
    end else begin
      // Close a number on any non-digit
      if (mode_cur == MODE_NUM) begin
        have_item = 1'b1;
        item      = acc_q;
        row_d     = 1'b1;
        acc_d     = '0;
        mode_d    = MODE_GAP;
      end
      priority if (is_digit) begin
        acc_d  = {{(VALUE_BITS-DIGIT_W){1'b0}}, digit};
        mode_d = MODE_NUM;
      end else if (is_nl) begin
        row_close = row_d;
        row_d     = 1'b0;
      end else if (!is_sep) begin
        mode_d = MODE_SKIP;
      end
    end

    // End of file: flush pending number, close row, clear mode, acc and row
    if (in_i.is_last) begin
      if (mode_d == MODE_NUM) begin
        have_item = 1'b1;
        item      = acc_d;
        row_d     = 1'b1;
      end
      if (row_d) begin
        row_close = 1'b1;
      end
      row_d  = 1'b0;
      acc_d  = '0;
      mode_d = MODE_GAP;
    end

    max_d = (have_item && (item > max_q)) ? item : max_q;
  end

  // Raise a word on an item or a row close, drop it once taken
  always_comb begin
    if (in_fire) begin
      out_valid_d = have_item || row_close;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_GAP;
      acc_q       <= '0;
      row_q       <= 1'b0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        mode_q <= mode_d;
        acc_q  <= acc_d;
        row_q  <= row_d;
        max_q  <= max_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_item_valid_q <= have_item;
      res_item_q       <= item;
      res_row_end_q    <= row_close;
    end
  end

  // Drive the result word; max_q only moves on accept, so it holds with the word
  assign out_o.valid      = out_valid_q;
  assign out_o.item_valid = res_item_valid_q;
  assign out_o.row_end    = res_row_end_q;

  if (VALUE_BITS >= ITEM_W) begin : g_out_trunc
    assign out_o.item_value   = res_item_q[ITEM_W-1:0];
    assign out_o.largest_item = max_q[ITEM_W-1:0];
  end else begin : g_out_ext
    assign out_o.item_value   = {{(ITEM_W-VALUE_BITS){1'b0}}, res_item_q};
    assign out_o.largest_item = {{(ITEM_W-VALUE_BITS){1'b0}}, max_q};
  end

  // Checks
  `TLIP_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, in_fire && in_i.is_last,
    mode_q == MODE_GAP && acc_q == '0 && !row_q, "scan state not cleared after last byte")
  `TLIP_ASSERT_IMPLY(a_word_has_event, clk_i, rst_ni, out_valid_q,
    res_item_valid_q || res_row_end_q, "result word carries neither item nor row end")
  `TLIP_ASSERT_IMPLY(a_max_covers_item, clk_i, rst_ni, out_valid_q && res_item_valid_q,
    res_item_q <= max_q, "running max below delivered item")
  `TLIP_ASSERT_NEXT(a_max_monotone, clk_i, rst_ni, 1'b1,
    max_q >= $past(max_q), "running max decreased")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transaction line-item parser testbench
// Streams text bytes into the parser and checks every result word against a
// cycle-free software model of the scanner. A directed text is followed by
// random rows of numbers, comments and junk under changing idle patterns,
// plus a long output hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module tb;
  import tlip_pkg::*;

  localparam int unsigned      HOLD_CYCLES    = 200;
  localparam int unsigned      WATCHDOG_LIMIT = 4000;
  localparam int unsigned      SETTLE_CYCLES  = 8;
  localparam logic [DATA_W-1:0] CHAR_HASH     = 8'h23;
  localparam logic [DATA_W-1:0] CHAR_PLUS     = 8'h2B;
  localparam logic [DATA_W-1:0] CHAR_MINUS    = 8'h2D;
  localparam logic [DATA_W-1:0] CHAR_VTAB     = 8'h0B;
  localparam logic [DATA_W-1:0] CHAR_FF       = 8'h0C;
  localparam logic [ITEM_W-1:0] ITEM_MAX      = '1;

  typedef struct packed {
    logic              item_valid;
    logic [ITEM_W-1:0] item_value;
    logic              row_end;
    logic [ITEM_W-1:0] largest_item;
  } parser_word_t;

  logic clk_i;
  logic rst_ni;

  tlip_in_if  in_ch ();
  tlip_out_if out_ch ();

  transaction_line_item_parser_top #(
    .VALUE_BITS(32)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Scanner model state
  logic [MODE_W-1:0] scan_mode = MODE_GAP;
  logic [ITEM_W-1:0] digit_acc = '0;
  logic              row_live  = 1'b0;
  logic [ITEM_W-1:0] model_max = '0;

  parser_word_t      expected_words[$];
  logic [DATA_W-1:0] text_q[$];
  int unsigned       bytes_sent   = 0;
  int unsigned       error_count  = 0;
  int unsigned       tx_idle_pct  = 0;
  int unsigned       rx_stall_pct = 0;
  logic              hold_active  = 1'b0;
  event              hold_off_ev;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Apply one byte to the scanner model and queue the word it produces
  function automatic void parse_byte(input logic [DATA_W-1:0] b, input logic last);
    logic [MODE_W-1:0]  mode;
    logic [DIGIT_W-1:0] d;
    logic               digit;
    logic               sep;
    logic               nl;
    logic               have_item;
    logic               row_close;
    logic [ITEM_W-1:0]  item;
    parser_word_t       w;
    digit     = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    sep       = (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_CR);
    nl        = (b == CHAR_NL);
    d         = DIGIT_W'(b - CHAR_ZERO);
    have_item = 1'b0;
    row_close = 1'b0;
    item      = '0;
    mode      = scan_mode;
    if (mode != MODE_NUM && mode != MODE_SKIP) mode = MODE_GAP;

    if (mode == MODE_NUM && digit) begin
      // saturate instead of wrapping
      if (digit_acc > (ITEM_MAX - ITEM_W'(d)) / 10) digit_acc = ITEM_MAX;
      else digit_acc = digit_acc * 10 + ITEM_W'(d);
    end else if (mode == MODE_SKIP) begin
      if (nl) begin
        row_close = row_live;
        row_live  = 1'b0;
        mode      = MODE_GAP;
      end
    end else begin
      // any non-digit closes a number in progress
      if (mode == MODE_NUM) begin
        have_item = 1'b1;
        item      = digit_acc;
        row_live  = 1'b1;
        digit_acc = '0;
        mode      = MODE_GAP;
      end
      if (digit) begin
        digit_acc = ITEM_W'(d);
        mode      = MODE_NUM;
      end else if (nl) begin
        row_close = row_live;
        row_live  = 1'b0;
      end else if (!sep) begin
        mode = MODE_SKIP;
      end
    end

    // End of file: flush the pending number and close the row
    if (last) begin
      if (mode == MODE_NUM) begin
        have_item = 1'b1;
        item      = digit_acc;
        row_live  = 1'b1;
      end
      if (row_live) row_close = 1'b1;
      row_live  = 1'b0;
      digit_acc = '0;
      mode      = MODE_GAP;
    end
    scan_mode = mode;

    if (have_item && item > model_max) model_max = item;
    if (have_item || row_close) begin
      w.item_valid   = have_item;
      w.item_value   = have_item ? item : '0;
      w.row_end      = row_close;
      w.largest_item = model_max;
      expected_words.push_back(w);
    end
  endfunction

  // Predict on every accepted input word
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && in_ch.valid && in_ch.ready) parse_byte(in_ch.data_byte, in_ch.is_last);
    end
  end

  // Compare every accepted result word with the oldest prediction
  initial begin
    parser_word_t exp_w;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with no prediction pending");
          error_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_ch.item_valid !== exp_w.item_valid) begin
            $error("item_valid: expected %0d, got %0d", exp_w.item_valid, out_ch.item_valid);
            error_count++;
          end
          if (out_ch.item_value !== exp_w.item_value) begin
            $error("item_value: expected %0d, got %0d", exp_w.item_value, out_ch.item_value);
            error_count++;
          end
          if (out_ch.row_end !== exp_w.row_end) begin
            $error("row_end: expected %0d, got %0d", exp_w.row_end, out_ch.row_end);
            error_count++;
          end
          if (out_ch.largest_item !== exp_w.largest_item) begin
            $error("largest_item: expected %0d, got %0d",
                   exp_w.largest_item, out_ch.largest_item);
            error_count++;
          end
        end
      end
    end
  end

  // Receiver: random stalls, or a solid hold-off while one is active
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_active) out_ch.ready <= 1'b0;
      else out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Hold off the receiver for a counted stretch on request
  initial begin
    forever begin
      @(hold_off_ev);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_active <= 1'b0;
    end
  end

  // Watchdog: end the run when neither channel moves for too long
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Offer one byte, idling first at the current rate, and wait for acceptance
  task automatic send_byte(input logic [DATA_W-1:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.is_last   <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Send the buffered text, marking its final byte as end of file if asked
  task automatic flush_text(input bit eof);
    int n;
    n = text_q.size();
    for (int i = 0; i < n; i++) send_byte(text_q[i], eof && (i == n - 1));
    text_q.delete();
  endtask

  task automatic put_sep();
    int n;
    n = $urandom_range(1, 2);
    repeat (n) begin
      case ($urandom_range(2))
        0:       text_q.push_back(CHAR_SPACE);
        1:       text_q.push_back(CHAR_TAB);
        default: text_q.push_back(CHAR_CR);
      endcase
    end
  endtask

  // Decimal number: mostly small, some full range, boundary and overflowing
  task automatic put_number();
    int n;
    case ($urandom_range(9))
      0, 1, 2, 3: put_str($sformatf("%0d", $urandom_range(999)));
      4, 5:       put_str($sformatf("%0d", $urandom()));
      6:          put_str("4294967295");
      7:          put_str("4294967296");
      8: begin
        n = $urandom_range(11, 14);
        repeat (n) text_q.push_back(CHAR_ZERO + DATA_W'($urandom_range(9)));
      end
      default:    put_str($sformatf("000%0d", $urandom_range(99)));
    endcase
  endtask

  // Junk token: a sign, a stray whitespace code or any other non-digit byte
  task automatic put_junk();
    logic [DATA_W-1:0] b;
    case ($urandom_range(4))
      0: text_q.push_back(CHAR_PLUS);
      1: text_q.push_back(CHAR_MINUS);
      2: text_q.push_back(CHAR_VTAB);
      3: text_q.push_back(CHAR_FF);
      default: begin
        b = DATA_W'($urandom_range(255));
        if ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_NL || b == CHAR_SPACE ||
            b == CHAR_TAB || b == CHAR_CR) b = CHAR_HASH;
        text_q.push_back(b);
      end
    endcase
    if ($urandom_range(1)) put_str($sformatf("%0d", $urandom_range(99)));
  endtask

  // One row of numbers with random separators, comment, junk and ending
  task automatic send_row();
    int n;
    int clen;
    bit eof;
    logic [DATA_W-1:0] b;
    n = $urandom_range(0, 5);
    if ($urandom_range(3) == 0) put_sep();
    for (int k = 0; k < n; k++) begin
      if (k != 0) put_sep();
      if ($urandom_range(19) == 0) put_junk();
      else put_number();
    end
    case ($urandom_range(9))
      0: begin
        if ($urandom_range(1)) put_sep();
        text_q.push_back(CHAR_HASH);
        clen = $urandom_range(8);
        repeat (clen) begin
          b = DATA_W'($urandom_range(255));
          text_q.push_back(b == CHAR_NL ? CHAR_SPACE : b);
        end
      end
      1:       put_sep();
      default: ;
    endcase
    eof = ($urandom_range(11) == 0);
    if (!eof || $urandom_range(1)) text_q.push_back(CHAR_NL);
    if (text_q.size() == 0) text_q.push_back(CHAR_SPACE);
    flush_text(eof);
  endtask

  // Raw bytes anywhere in the code space, end of file now and then
  task automatic send_noise(input int n);
    repeat (n) send_byte(DATA_W'($urandom_range(255)), $urandom_range(49) == 0);
  endtask

  // Directed text: item ended by CR, a sign as junk, empty row, item ended by
  // comment and by junk, overflow with row end together, flush at end of file
  task automatic test_directed_text();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    put_str("0\r+7\n\n42#\n8x\n4294967296\n");
    flush_text(1'b0);
    put_str("5");
    flush_text(1'b1);
  endtask

  task automatic test_random_text(input int unsigned tx_pct, input int unsigned rx_pct,
                                  input int unsigned goal);
    int unsigned stop_at;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    stop_at      = bytes_sent + goal;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(9) == 0) send_noise($urandom_range(1, 6));
      else send_row();
    end
  endtask

  // Keep offering bytes while the receiver is held off
  task automatic test_backpressure();
    int unsigned stop_at;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    stop_at      = bytes_sent + 60;
    -> hold_off_ev;
    while (bytes_sent < stop_at) send_row();
  endtask

  // Main sequence
  initial begin
    rst_ni          <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.is_last   <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_text();
    test_random_text(7, 65, 290);
    test_backpressure();
    test_random_text(65, 7, 290);
    test_random_text(0, 0, 290);

    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (error_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/tlip_pkg.sv
src/tlip_in_if.sv
src/tlip_out_if.sv
src/tlip_digit_acc.sv
src/transaction_line_item_parser_top.sv
tb/sv/tb.sv
